// ===== sv/triangle_barycentric_coords_macros.svh =====
// Assertion macros for the triangle barycentric coordinates block.
// Used by the checker module; needs clk and arst_n in the calling scope.
`ifndef TRIANGLE_BARYCENTRIC_COORDS_MACROS_SVH
`define TRIANGLE_BARYCENTRIC_COORDS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TBC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tbc_pkg.sv =====
// Package for the triangle barycentric coordinates block.
// Holds the configuration register indexes; no dependencies.
package tbc_pkg;

	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CORNER_X0 = 3'd0,
		REG_CORNER_Y0 = 3'd1,
		REG_CORNER_X1 = 3'd2,
		REG_CORNER_Y1 = 3'd3,
		REG_CORNER_X2 = 3'd4,
		REG_CORNER_Y2 = 3'd5
	} tbc_reg_t;

endpackage

// ===== sv/triangle_barycentric_coords.sv =====
// Barycentric coordinates of query points against a configured triangle.
// Top level; depends on tbc_pkg.
//
// Usage:
// The six corner registers are written through cfg_we, cfg_index and cfg_data,
// one register per cycle; the user must write them only while no transaction is
// in flight, which the block itself does not enforce. Writes to indexes beyond
// the six registers are ignored. Query points enter on the point channel and
// results leave on the result channel, both valid/ready. Four stages form the
// cross products and their magnitudes, one restoring divider stage per quotient
// bit (2*COORD_WIDTH + FRAC_BITS + 3 stages, two dividers side by side) forms
// the rounded quotients, and two stages sign, sum and saturate them.
// Throughput is one transaction per cycle while the receiver keeps up.
// All stages advance together; when the output register holds a result that is
// not taken, the whole pipeline holds and point_ready is low. Nothing is lost.
// Reset clears the corners to zero and empties the pipeline; a query against
// the reset triangle reports degenerate with zero weights.
module triangle_barycentric_coords
	import tbc_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	input  logic                          point_valid,
	output logic                          point_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [COORD_WIDTH-1:0] bary_0,
	output logic signed [COORD_WIDTH-1:0] bary_1,
	output logic signed [COORD_WIDTH-1:0] bary_2,
	output logic                          degenerate,
	output logic                          saturated
);

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int DW = W + 1;
	localparam int PW = 2 * W + 2;
	localparam int CW = 2 * W + 3;
	localparam int MW = 2 * W + 2;
	localparam int RW = 2 * W + 3;
	localparam int NW = 2 * W + 3 + F;
	localparam int QW = NW + 1;
	localparam int SW = NW + 3;

	localparam logic signed [SW-1:0] SMAX  = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN  = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [SW-1:0] ONE_S = SW'(1) <<< F;

	logic signed [W-1:0] corner_x0_q, corner_y0_q, corner_x1_q;
	logic signed [W-1:0] corner_y1_q, corner_x2_q, corner_y2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_x0_q <= '0;
			corner_y0_q <= '0;
			corner_x1_q <= '0;
			corner_y1_q <= '0;
			corner_x2_q <= '0;
			corner_y2_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CORNER_X0: corner_x0_q <= cfg_data;
				REG_CORNER_Y0: corner_y0_q <= cfg_data;
				REG_CORNER_X1: corner_x1_q <= cfg_data;
				REG_CORNER_Y1: corner_y1_q <= cfg_data;
				REG_CORNER_X2: corner_x2_q <= cfg_data;
				REG_CORNER_Y2: corner_y2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s5, v_out_q;
	logic v_sd [0:NW];

	assign en          = !v_out_q || result_ready;
	assign point_ready = en;

	// Stage 1: coordinate differences.
	logic signed [DW-1:0] dx0_s1, dx1_s1, dx2_s1, dy0_s1, dy1_s1, dy2_s1;
	logic signed [DW-1:0] ex1_s1, ex2_s1, ey1_s1, ey2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx0_s1 <= DW'(corner_x0_q) - DW'(point_x);
			dx1_s1 <= DW'(corner_x1_q) - DW'(point_x);
			dx2_s1 <= DW'(corner_x2_q) - DW'(point_x);
			dy0_s1 <= DW'(corner_y0_q) - DW'(point_y);
			dy1_s1 <= DW'(corner_y1_q) - DW'(point_y);
			dy2_s1 <= DW'(corner_y2_q) - DW'(point_y);
			ex1_s1 <= DW'(corner_x1_q) - DW'(corner_x0_q);
			ex2_s1 <= DW'(corner_x2_q) - DW'(corner_x0_q);
			ey1_s1 <= DW'(corner_y1_q) - DW'(corner_y0_q);
			ey2_s1 <= DW'(corner_y2_q) - DW'(corner_y0_q);
		end
	end

	// Stage 2: products.
	logic signed [PW-1:0] p0a_s2, p0b_s2, p1a_s2, p1b_s2, pda_s2, pdb_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p0a_s2 <= dx1_s1 * dy2_s1;
			p0b_s2 <= dx2_s1 * dy1_s1;
			p1a_s2 <= dx2_s1 * dy0_s1;
			p1b_s2 <= dx0_s1 * dy2_s1;
			pda_s2 <= ex1_s1 * ey2_s1;
			pdb_s2 <= ex2_s1 * ey1_s1;
		end
	end

	// Stage 3: cross products.
	logic signed [CW-1:0] n0_s3, n1_s3, dd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			n0_s3 <= CW'(p0a_s2) - CW'(p0b_s2);
			n1_s3 <= CW'(p1a_s2) - CW'(p1b_s2);
			dd_s3 <= CW'(pda_s2) - CW'(pdb_s2);
		end
	end

	// Stage 4 is divider stage zero: magnitudes, rounding numerators, signs.
	logic [RW-1:0] rem0_sd [0:NW];
	logic [RW-1:0] rem1_sd [0:NW];
	logic [NW-1:0] nq0_sd  [0:NW];
	logic [NW-1:0] nq1_sd  [0:NW];
	logic [RW-1:0] den_sd  [0:NW];
	logic          neg0_sd [0:NW];
	logic          neg1_sd [0:NW];
	logic          dg_sd   [0:NW];

	logic [MW-1:0] mag0, mag1, magd;

	always_comb begin
		mag0 = MW'(n0_s3[CW-1] ? -n0_s3 : n0_s3);
		mag1 = MW'(n1_s3[CW-1] ? -n1_s3 : n1_s3);
		magd = MW'(dd_s3[CW-1] ? -dd_s3 : dd_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem0_sd[0] <= '0;
			rem1_sd[0] <= '0;
			nq0_sd[0]  <= (NW'(mag0) << (F + 1)) + NW'(magd);
			nq1_sd[0]  <= (NW'(mag1) << (F + 1)) + NW'(magd);
			den_sd[0]  <= {magd, 1'b0};
			neg0_sd[0] <= n0_s3[CW-1] ^ dd_s3[CW-1];
			neg1_sd[0] <= n1_s3[CW-1] ^ dd_s3[CW-1];
			dg_sd[0]   <= (dd_s3 == '0);
		end
	end

	// Restoring division, one quotient bit per stage, quotient shifted into nq.
	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [RW:0]   t0, t1;
		logic [RW+1:0] df0, df1;

		always_comb begin
			t0  = {rem0_sd[k], nq0_sd[k][NW-1]};
			t1  = {rem1_sd[k], nq1_sd[k][NW-1]};
			df0 = {1'b0, t0} - {2'b00, den_sd[k]};
			df1 = {1'b0, t1} - {2'b00, den_sd[k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem0_sd[k+1] <= df0[RW+1] ? t0[RW-1:0] : df0[RW-1:0];
				rem1_sd[k+1] <= df1[RW+1] ? t1[RW-1:0] : df1[RW-1:0];
				nq0_sd[k+1]  <= {nq0_sd[k][NW-2:0], !df0[RW+1]};
				nq1_sd[k+1]  <= {nq1_sd[k][NW-2:0], !df1[RW+1]};
				den_sd[k+1]  <= den_sd[k];
				neg0_sd[k+1] <= neg0_sd[k];
				neg1_sd[k+1] <= neg1_sd[k];
				dg_sd[k+1]   <= dg_sd[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (en) begin
				v_sd[k+1] <= v_sd[k];
			end
		end
	end

	// Stage 5: signed quotients.
	logic signed [QW-1:0] q0_s5, q1_s5;
	logic                 dg_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			q0_s5 <= neg0_sd[NW] ? -QW'(nq0_sd[NW]) : QW'(nq0_sd[NW]);
			q1_s5 <= neg1_sd[NW] ? -QW'(nq1_sd[NW]) : QW'(nq1_sd[NW]);
			dg_s5 <= dg_sd[NW];
		end
	end

	// Output stage: third weight and saturation.
	function automatic logic [W:0] sat(input logic signed [SW-1:0] v);
		logic [W:0] r;
		if (v > SMAX) begin
			r = {1'b1, SMAX[W-1:0]};
		end else if (v < SMIN) begin
			r = {1'b1, SMIN[W-1:0]};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	logic signed [SW-1:0] q2_full;
	logic [W:0]           sat0, sat1, sat2;

	always_comb begin
		q2_full = ONE_S - (SW'(q0_s5) + SW'(q1_s5));
		sat0    = sat(SW'(q0_s5));
		sat1    = sat(SW'(q1_s5));
		sat2    = sat(q2_full);
	end

	logic signed [W-1:0] bary_0_q, bary_1_q, bary_2_q;
	logic                degenerate_q, saturated_q;

	always_ff @(posedge clk) begin
		if (en) begin
			bary_0_q     <= dg_s5 ? '0 : sat0[W-1:0];
			bary_1_q     <= dg_s5 ? '0 : sat1[W-1:0];
			bary_2_q     <= dg_s5 ? '0 : sat2[W-1:0];
			degenerate_q <= dg_s5;
			saturated_q  <= !dg_s5 && (sat0[W] || sat1[W] || sat2[W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_sd[0] <= 1'b0;
			v_s5    <= 1'b0;
			v_out_q <= 1'b0;
		end else if (en) begin
			v_s1    <= point_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_sd[0] <= v_s3;
			v_s5    <= v_sd[NW];
			v_out_q <= v_s5;
		end
	end

	assign result_valid = v_out_q;
	assign bary_0       = bary_0_q;
	assign bary_1       = bary_1_q;
	assign bary_2       = bary_2_q;
	assign degenerate   = degenerate_q;
	assign saturated    = saturated_q;

endmodule

// ===== sv/tbc_checker.sv =====
// Port-level checker for the triangle barycentric coordinates block.
// Depends on tbc_pkg and triangle_barycentric_coords_macros.svh; bound to the top level.
`include "triangle_barycentric_coords_macros.svh"

module tbc_checker
	import tbc_pkg::*;
#(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [CFG_INDEX_W-1:0]        cfg_index,
	input logic [COORD_WIDTH-1:0]        cfg_data,
	input logic                          point_valid,
	input logic                          point_ready,
	input logic signed [COORD_WIDTH-1:0] point_x,
	input logic signed [COORD_WIDTH-1:0] point_y,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic signed [COORD_WIDTH-1:0] bary_0,
	input logic signed [COORD_WIDTH-1:0] bary_1,
	input logic signed [COORD_WIDTH-1:0] bary_2,
	input logic                          degenerate,
	input logic                          saturated
);

	localparam logic [COORD_WIDTH-1:0] ONE = COORD_WIDTH'(1) << FRAC_BITS;

	logic [COORD_WIDTH-1:0] wsum;
	assign wsum = bary_0 + bary_1 + bary_2;

	`TBC_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid,
		"result transaction dropped while stalled")
	`TBC_ASSERT_NEXT(a_out_stable, result_valid && !result_ready,
		$stable(bary_0) && $stable(bary_1) && $stable(bary_2) && $stable(degenerate),
		"result payload changed while stalled")
	`TBC_ASSERT_NOW(a_degen_zero, result_valid && degenerate,
		bary_0 == '0 && bary_1 == '0 && bary_2 == '0 && !saturated,
		"degenerate result with nonzero weights")
	`TBC_ASSERT_NOW(a_sum_one, result_valid && !degenerate && !saturated, wsum == ONE,
		"unclipped weights do not sum to one")

endmodule

bind triangle_barycentric_coords tbc_checker #(
	.COORD_WIDTH(COORD_WIDTH),
	.FRAC_BITS(FRAC_BITS)
) u_tbc_checker (.*);
